[rtl/vrtk_pkg.sv]
// Shared types and constants for the vector ring top-k cosine search block.
`default_nettype none
package vrtk_pkg;

   localparam int COMPONENTS = 8;
   localparam int COMP_W     = 16;
   localparam int SLOT_W     = 6;
   localparam int RANK_W     = 3;
   localparam int SCORE_W    = 16;
   localparam int UID_W      = 8;

   localparam logic [UID_W-1:0]   FILTER_ALL = 8'hFF;
   localparam logic [SCORE_W-1:0] SCORE_ONE  = 16'h8000;

   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_SEARCH   = 1'b1;
   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef logic [COMP_W-1:0] comp_type;
   typedef comp_type [COMPONENTS-1:0] vec_type;

   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic [SLOT_W-1:0]  slot;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [SCORE_W-1:0] score;
      logic [RANK_W-1:0]  rank;
      logic               has_match;
      logic               last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACK,
      ST_READ,
      ST_CHECK,
      ST_SCORE,
      ST_DRAIN,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MAC,
      SC_ROOT,
      SC_MUL,
      SC_DIV
   } score_state_type;

endpackage
`default_nettype wire

[rtl/vrtk_req_if.sv]
// Request channel interface: operation, owner id and query or insert vector.
`default_nettype none
interface vrtk_req_if;
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [7:0]             user_id;
   vrtk_pkg::comp_type     component_0;
   vrtk_pkg::comp_type     component_1;
   vrtk_pkg::comp_type     component_2;
   vrtk_pkg::comp_type     component_3;
   vrtk_pkg::comp_type     component_4;
   vrtk_pkg::comp_type     component_5;
   vrtk_pkg::comp_type     component_6;
   vrtk_pkg::comp_type     component_7;

   modport source (
      output valid, operation, user_id, component_0, component_1, component_2,
             component_3, component_4, component_5, component_6, component_7,
      input  ready
   );
   modport sink (
      input  valid, operation, user_id, component_0, component_1, component_2,
             component_3, component_4, component_5, component_6, component_7,
      output ready
   );
endinterface
`default_nettype wire

[rtl/vrtk_rsp_if.sv]
// Response channel interface: insert acknowledgements and ranked search results.
`default_nettype none
interface vrtk_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [5:0]  slot;
   logic [15:0] score;
   logic [2:0]  rank;
   logic        has_match;
   logic        last;

   modport source (
      output valid, kind, slot, score, rank, has_match, last,
      input  ready
   );
   modport sink (
      input  valid, kind, slot, score, rank, has_match, last,
      output ready
   );
endinterface
`default_nettype wire

[rtl/vrtk_score.sv]
// Iterative cosine score unit: dot and norms, integer roots, restoring divide.
`default_nettype none
module vrtk_score (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  vrtk_pkg::vec_type     query,
   input  vrtk_pkg::vec_type     entry,
   output logic                  done,
   output logic [15:0]           score
);

   vrtk_pkg::score_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [34:0] dot_ff, dot_in;
   logic [34:0] na_ff, na_in;
   logic [34:0] nb_ff, nb_in;
   logic [35:0] ra_ff, ra_in;
   logic [35:0] rb_ff, rb_in;
   logic [34:0] bit_ff, bit_in;
   logic [35:0] denom_ff, denom_in;
   logic [52:0] rem_ff, rem_in;
   logic [52:0] dsh_ff, dsh_in;
   logic [15:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic [15:0] score_ff, score_in;

   always_comb begin
      logic [15:0] a;
      logic [15:0] b;
      logic [31:0] p_ab;
      logic [31:0] p_aa;
      logic [31:0] p_bb;
      logic [35:0] ta;
      logic [35:0] tb;
      logic [35:0] prod;
      logic        ge;
      logic [16:0] q;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dot_in   = dot_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      bit_in   = bit_ff;
      denom_in = denom_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      score_in = score_ff;
      a    = query[cnt_ff[2:0]];
      b    = entry[cnt_ff[2:0]];
      p_ab = a * b;
      p_aa = a * a;
      p_bb = b * b;
      ta   = ra_ff + {1'b0, bit_ff};
      tb   = rb_ff + {1'b0, bit_ff};
      prod = ra_ff[17:0] * rb_ff[17:0];
      ge   = rem_ff >= dsh_ff;
      q    = {quo_ff, ge};
      unique case (state_ff)
         vrtk_pkg::SC_IDLE: begin
            if (start) begin
               cnt_in   = '0;
               dot_in   = '0;
               na_in    = '0;
               nb_in    = '0;
               state_in = vrtk_pkg::SC_MAC;
            end
         end
         vrtk_pkg::SC_MAC: begin
            dot_in = dot_ff + {3'b0, p_ab};
            na_in  = na_ff + {3'b0, p_aa};
            nb_in  = nb_ff + {3'b0, p_bb};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(vrtk_pkg::COMPONENTS - 1)) begin
               cnt_in   = '0;
               ra_in    = '0;
               rb_in    = '0;
               bit_in   = 35'd1 << 34;
               state_in = vrtk_pkg::SC_ROOT;
            end
         end
         vrtk_pkg::SC_ROOT: begin
            if ({1'b0, na_ff} >= ta) begin
               na_in = na_ff - ta[34:0];
               ra_in = (ra_ff >> 1) + {1'b0, bit_ff};
            end else begin
               ra_in = ra_ff >> 1;
            end
            if ({1'b0, nb_ff} >= tb) begin
               nb_in = nb_ff - tb[34:0];
               rb_in = (rb_ff >> 1) + {1'b0, bit_ff};
            end else begin
               rb_in = rb_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd17) begin
               state_in = vrtk_pkg::SC_MUL;
            end
         end
         vrtk_pkg::SC_MUL: begin
            denom_in = prod;
            state_in = vrtk_pkg::SC_DIV;
            cnt_in   = 5'd16;
            rem_in   = {3'b0, dot_ff, 15'b0};
            dsh_in   = {1'b0, prod, 16'b0};
            quo_in   = '0;
         end
         vrtk_pkg::SC_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            quo_in = q[15:0];
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               done_in  = 1'b1;
               state_in = vrtk_pkg::SC_IDLE;
               if (denom_ff == '0) begin
                  score_in = '0;
               end else if (q > {1'b0, vrtk_pkg::SCORE_ONE}) begin
                  score_in = vrtk_pkg::SCORE_ONE;
               end else begin
                  score_in = q[15:0];
               end
            end
         end
         default: state_in = vrtk_pkg::SC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vrtk_pkg::SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      dot_ff   <= dot_in;
      na_ff    <= na_in;
      nb_ff    <= nb_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      bit_ff   <= bit_in;
      denom_ff <= denom_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      score_ff <= score_in;
   end

   assign done  = done_ff;
   assign score = score_ff;

endmodule
`default_nettype wire

[rtl/vrtk_rank_cell.sv]
// One cell of the sorted best list: keep the better entry, pass the other on.
`default_nettype none
module vrtk_rank_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  vrtk_pkg::cell_ctrl_type ctrl,
   input  vrtk_pkg::entry_type     cand_in,
   input  vrtk_pkg::entry_type     right_in,
   output vrtk_pkg::entry_type     held,
   output vrtk_pkg::entry_type     pass
);

   vrtk_pkg::entry_type held_ff, held_in;
   vrtk_pkg::entry_type pass_ff, pass_in;

   always_comb begin
      held_in       = held_ff;
      pass_in       = cand_in;
      pass_in.valid = 1'b0;
      if (ctrl.clear) begin
         held_in.valid = 1'b0;
      end else if (ctrl.shift) begin
         held_in = right_in;
      end else if (cand_in.valid) begin
         if (!held_ff.valid) begin
            held_in = cand_in;
         end else if (cand_in.score > held_ff.score) begin
            held_in = cand_in;
            pass_in = held_ff;
         end else begin
            pass_in = cand_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         pass_ff.valid <= pass_in.valid;
      end
      held_ff.score <= held_in.score;
      held_ff.slot  <= held_in.slot;
      pass_ff.score <= pass_in.score;
      pass_ff.slot  <= pass_in.slot;
   end

   assign held = held_ff;
   assign pass = pass_ff;

endmodule
`default_nettype wire

[rtl/vector_ring_top_k_cosine_search.sv]
// Top level: vector ring store, scan control, best-list cell chain, response register.
//
// An insert writes the ring entry in the cycle it is accepted; its acknowledgement
// passes through the ACK state into the response register once that is free. A
// search walks the stored entries newest first: an entry whose owner fails the
// filter takes a read and a filter step, a scored entry takes a read and a filter
// step, 8 multiply-accumulate steps, 18 square-root steps, one root product, 17
// divide steps and a step to take the score; then the best-list chain is drained
// and each result takes one cycle while the response side is ready. One request
// is worked on at a time; the response register lets a new request enter while a
// result waits.
`default_nettype none
module vector_ring_top_k_cosine_search #(
   parameter int RING_DEPTH = 64,
   parameter int TOP_COUNT  = 4
) (
   input wire logic    clock,
   input wire logic    reset,
   vrtk_req_if.sink    req_chan,
   vrtk_rsp_if.source  rsp_chan
);

   localparam int ADDR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W  = $clog2(RING_DEPTH + 1);
   localparam int DRAIN_W = $clog2(TOP_COUNT + 1);

   vrtk_pkg::vec_type   vec_mem [RING_DEPTH];
   logic [7:0]          owner_mem [RING_DEPTH];
   vrtk_pkg::vec_type   rd_vec_ff;
   logic [7:0]          rd_owner_ff;

   vrtk_pkg::ctrl_state_type state_ff, state_in;
   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   idx_ff, idx_in;
   logic [DRAIN_W-1:0]  drain_ff, drain_in;
   logic [2:0]          rank_ff, rank_in;
   vrtk_pkg::vec_type   query_ff, query_in;
   logic [7:0]          filter_ff, filter_in;
   logic                rsp_valid_ff, rsp_valid_in;
   vrtk_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   vrtk_pkg::vec_type       req_vec;
   logic                    mem_we;
   logic                    score_start;
   logic                    score_done;
   logic [15:0]             score_val;
   vrtk_pkg::cell_ctrl_type cell_ctrl;
   vrtk_pkg::entry_type     cand;
   vrtk_pkg::entry_type     held_w [TOP_COUNT+1];
   vrtk_pkg::entry_type     pass_w [TOP_COUNT];
   logic [ADDR_W+5:0]       addr_wide;
   logic                    rsp_free;

   assign req_vec[0] = req_chan.component_0;
   assign req_vec[1] = req_chan.component_1;
   assign req_vec[2] = req_chan.component_2;
   assign req_vec[3] = req_chan.component_3;
   assign req_vec[4] = req_chan.component_4;
   assign req_vec[5] = req_chan.component_5;
   assign req_vec[6] = req_chan.component_6;
   assign req_vec[7] = req_chan.component_7;

   assign addr_wide = {6'b0, addr_ff};
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == vrtk_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vec_mem[wp_ff]   <= req_vec;
         owner_mem[wp_ff] <= req_chan.user_id;
      end
      rd_vec_ff   <= vec_mem[addr_ff];
      rd_owner_ff <= owner_mem[addr_ff];
   end

   vrtk_score u_score (
      .clock (clock),
      .reset (reset),
      .start (score_start),
      .query (query_ff),
      .entry (rd_vec_ff),
      .done  (score_done),
      .score (score_val)
   );

   assign held_w[TOP_COUNT] = '0;

   for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
      vrtk_rank_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .cand_in  ((i == 0) ? cand : pass_w[(i == 0) ? 0 : i - 1]),
         .right_in (held_w[i+1]),
         .held     (held_w[i]),
         .pass     (pass_w[i])
      );
   end

   always_comb begin
      logic advance;
      logic [FILL_W-1:0] idx_nx;
      state_in     = state_ff;
      wp_in        = wp_ff;
      addr_in      = addr_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      drain_in     = drain_ff;
      rank_in      = rank_ff;
      query_in     = query_ff;
      filter_in    = filter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_item_in  = rsp_item_ff;
      mem_we       = 1'b0;
      score_start  = 1'b0;
      cell_ctrl    = '0;
      cand.valid   = 1'b0;
      cand.score   = score_val;
      cand.slot    = addr_wide[5:0];
      advance      = 1'b0;
      idx_nx       = idx_ff + FILL_W'(1);
      unique case (state_ff)
         vrtk_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.operation == vrtk_pkg::OP_INSERT) begin
                  mem_we   = 1'b1;
                  addr_in  = wp_ff;
                  wp_in    = (wp_ff == ADDR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + ADDR_W'(1);
                  if (fill_ff != FILL_W'(RING_DEPTH)) begin
                     fill_in = fill_ff + FILL_W'(1);
                  end
                  state_in = vrtk_pkg::ST_ACK;
               end else begin
                  query_in  = req_vec;
                  filter_in = req_chan.user_id;
                  cell_ctrl.clear = 1'b1;
                  idx_in    = '0;
                  addr_in   = (wp_ff == '0) ? ADDR_W'(RING_DEPTH - 1) : wp_ff - ADDR_W'(1);
                  rank_in   = '0;
                  state_in  = (fill_ff == '0) ? vrtk_pkg::ST_EMIT : vrtk_pkg::ST_READ;
               end
            end
         end
         vrtk_pkg::ST_ACK: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.kind      = vrtk_pkg::KIND_ACK;
               rsp_item_in.slot      = addr_wide[5:0];
               rsp_item_in.score     = '0;
               rsp_item_in.rank      = '0;
               rsp_item_in.has_match = 1'b0;
               rsp_item_in.last      = 1'b1;
               state_in              = vrtk_pkg::ST_IDLE;
            end
         end
         vrtk_pkg::ST_READ: begin
            state_in = vrtk_pkg::ST_CHECK;
         end
         vrtk_pkg::ST_CHECK: begin
            if (filter_ff == vrtk_pkg::FILTER_ALL || rd_owner_ff == filter_ff) begin
               score_start = 1'b1;
               state_in    = vrtk_pkg::ST_SCORE;
            end else begin
               advance = 1'b1;
            end
         end
         vrtk_pkg::ST_SCORE: begin
            if (score_done) begin
               cand.valid = 1'b1;
               advance    = 1'b1;
            end
         end
         vrtk_pkg::ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (drain_ff == DRAIN_W'(TOP_COUNT - 1)) begin
               state_in = vrtk_pkg::ST_EMIT;
            end
         end
         vrtk_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_item_in.kind = vrtk_pkg::KIND_SEARCH;
               if (!held_w[0].valid) begin
                  rsp_item_in.slot      = '0;
                  rsp_item_in.score     = '0;
                  rsp_item_in.rank      = '0;
                  rsp_item_in.has_match = 1'b0;
                  rsp_item_in.last      = 1'b1;
                  state_in              = vrtk_pkg::ST_IDLE;
               end else begin
                  rsp_item_in.slot      = held_w[0].slot;
                  rsp_item_in.score     = held_w[0].score;
                  rsp_item_in.rank      = rank_ff;
                  rsp_item_in.has_match = 1'b1;
                  rsp_item_in.last      = !held_w[1].valid;
                  cell_ctrl.shift       = 1'b1;
                  rank_in               = rank_ff + 3'd1;
                  if (!held_w[1].valid) begin
                     state_in = vrtk_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = vrtk_pkg::ST_IDLE;
      endcase
      if (advance) begin
         idx_in   = idx_nx;
         addr_in  = (addr_ff == '0) ? ADDR_W'(RING_DEPTH - 1) : addr_ff - ADDR_W'(1);
         drain_in = '0;
         state_in = (idx_nx == fill_ff) ? vrtk_pkg::ST_DRAIN : vrtk_pkg::ST_READ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrtk_pkg::ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      idx_ff      <= idx_in;
      drain_ff    <= drain_in;
      rank_ff     <= rank_in;
      query_ff    <= query_in;
      filter_ff   <= filter_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.kind      = rsp_item_ff.kind;
   assign rsp_chan.slot      = rsp_item_ff.slot;
   assign rsp_chan.score     = rsp_item_ff.score;
   assign rsp_chan.rank      = rsp_item_ff.rank;
   assign rsp_chan.has_match = rsp_item_ff.has_match;
   assign rsp_chan.last      = rsp_item_ff.last;

endmodule
`default_nettype wire
